// ===== sv/i2cmps_pkg.sv =====
// Shared types, codes and phase decode functions for the I2C master phase sequencer.
// No dependencies; imported by the phase timer and the sequencer core.
package i2cmps_pkg;

   localparam int CmdW   = 3;
   localparam int ByteW  = 8;
   localparam int StepW  = 6;
   localparam int TickW  = 16;
   localparam int KindW  = 4;

   // Highest step value ever held: probe runs three start phases and nineteen write phases.
   localparam logic [StepW-1:0] MaxStep = 6'd22;

   // Commands
   localparam logic [CmdW-1:0] CmdNone    = 3'd0;
   localparam logic [CmdW-1:0] CmdStart   = 3'd1;
   localparam logic [CmdW-1:0] CmdStop    = 3'd2;
   localparam logic [CmdW-1:0] CmdWrite   = 3'd3;
   localparam logic [CmdW-1:0] CmdRead    = 3'd4;
   localparam logic [CmdW-1:0] CmdProbe   = 3'd5;
   localparam logic [CmdW-1:0] CmdSendAck = 3'd6;
   localparam logic [CmdW-1:0] CmdRecvAck = 3'd7;

   // Phase kinds
   localparam logic [KindW-1:0] KindEnd      = 4'd0;
   localparam logic [KindW-1:0] KindDriveHi  = 4'd1;
   localparam logic [KindW-1:0] KindSclHi    = 4'd2;
   localparam logic [KindW-1:0] KindDriveLo  = 4'd3;
   localparam logic [KindW-1:0] KindStopLo   = 4'd4;
   localparam logic [KindW-1:0] KindBitLow   = 4'd5;
   localparam logic [KindW-1:0] KindRelLow   = 4'd6;
   localparam logic [KindW-1:0] KindAckHi    = 4'd7;
   localparam logic [KindW-1:0] KindSclLo    = 4'd8;
   localparam logic [KindW-1:0] KindReadHi   = 4'd9;
   localparam logic [KindW-1:0] KindAckDrive = 4'd10;

   typedef struct packed {
      logic clear;   // drop back to zero (sequence finished)
      logic load;    // a new phase is entered: restart at one
      logic count;   // a request arrived inside a running phase
   } timer_ctl_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic sda_en;
   } bus_levels_type;

   function automatic logic [KindW-1:0] start_kind(input logic [StepW-1:0] idx);
      logic [KindW-1:0] k;
      k = KindEnd;
      if (idx == 6'd0) k = KindDriveHi;
      else if (idx == 6'd1) k = KindSclHi;
      else if (idx == 6'd2) k = KindDriveLo;
      return k;
   endfunction

   function automatic logic [KindW-1:0] write_kind(input logic [StepW-1:0] idx);
      logic [KindW-1:0] k;
      k = KindEnd;
      if (idx < 6'd16) k = idx[0] ? KindSclHi : KindBitLow;
      else if (idx == 6'd16) k = KindRelLow;
      else if (idx == 6'd17) k = KindAckHi;
      else if (idx == 6'd18) k = KindSclLo;
      return k;
   endfunction

   function automatic logic [KindW-1:0] phase_kind(input logic [CmdW-1:0] cmd,
                                                   input logic [StepW-1:0] idx);
      logic [KindW-1:0] k;
      k = KindEnd;
      case (cmd)
         CmdStart: k = start_kind(idx);
         CmdStop: begin
            if (idx == 6'd0) k = KindStopLo;
            else if (idx == 6'd1) k = KindDriveHi;
         end
         CmdWrite: k = write_kind(idx);
         CmdRead: begin
            if (idx < 6'd16) k = idx[0] ? KindSclLo : KindReadHi;
            else if (idx == 6'd16) k = KindAckDrive;
            else if (idx == 6'd17) k = KindSclHi;
            else if (idx == 6'd18) k = KindSclLo;
         end
         CmdProbe: k = (idx < 6'd3) ? start_kind(idx) : write_kind(idx - 6'd3);
         CmdSendAck: begin
            if (idx == 6'd0) k = KindAckDrive;
            else if (idx == 6'd1) k = KindSclHi;
            else if (idx == 6'd2) k = KindSclLo;
         end
         CmdRecvAck: begin
            if (idx == 6'd0) k = KindAckHi;
            else if (idx == 6'd1) k = KindSclLo;
         end
         default: k = KindEnd;
      endcase
      return k;
   endfunction

   // Bus levels set on entry to a phase; levels not named by the phase hold.
   function automatic bus_levels_type enter_phase(input logic [KindW-1:0]  kind,
                                                  input logic [CmdW-1:0]   cmd,
                                                  input logic [StepW-1:0]  idx,
                                                  input logic [ByteW-1:0]  shifter,
                                                  input bus_levels_type    cur);
      bus_levels_type  lv;
      logic [StepW-1:0] w;
      logic [2:0]       bit_pos;
      lv      = cur;
      w       = (cmd == CmdProbe) ? idx - 6'd3 : idx;
      bit_pos = w[3:1];
      unique case (kind) inside
         KindDriveHi: begin
            lv.sda_en = 1'b1;
            lv.sda    = 1'b1;
         end
         KindSclHi: lv.scl = 1'b1;
         KindDriveLo: begin
            lv.sda_en = 1'b1;
            lv.sda    = 1'b0;
         end
         KindStopLo: begin
            lv.sda_en = 1'b1;
            lv.sda    = 1'b0;
            lv.scl    = 1'b1;
         end
         KindBitLow: begin
            lv.scl    = 1'b0;
            lv.sda_en = 1'b1;
            lv.sda    = shifter[3'd7 - bit_pos];
         end
         KindRelLow: begin
            lv.scl    = 1'b0;
            lv.sda_en = 1'b0;
         end
         KindAckHi, KindReadHi: begin
            lv.sda_en = 1'b0;
            lv.scl    = 1'b1;
         end
         KindSclLo: lv.scl = 1'b0;
         KindAckDrive: begin
            lv.sda_en = 1'b1;
            lv.sda    = (cmd == CmdSendAck) ? shifter[0] : 1'b0;
         end
         default: lv = cur;
      endcase
      return lv;
   endfunction

endpackage

// ===== sv/i2cmps_phase_timer.sv =====
// Phase duration counter: counts requests inside the current bus phase.
// Depends on i2cmps_pkg for widths and the timer control struct.
module i2cmps_phase_timer import i2cmps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  timer_ctl_type    ctl,
   input  logic [TickW-1:0] phase_ticks,
   output logic             expired
);

   logic [TickW-1:0] count_ff;
   logic [TickW-1:0] count_in;
   logic [TickW-1:0] limit;

   // A zero setting behaves as one tick per phase.
   assign limit   = (phase_ticks == '0) ? TickW'(1) : phase_ticks;
   assign expired = (count_ff >= limit);

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) count_in = '0;
      else if (ctl.load) count_in = TickW'(1);
      else if (ctl.count) count_in = count_ff + TickW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

endmodule

// ===== sv/i2c_master_phase_sequencer_core.sv =====
// I2C master phase sequencer: one request per time-base tick, one response per request.
// The response for a request is in the output register from the cycle after acceptance.
// Throughput: one request every cycle unless stalled; state update is one decode pass.
// The output register lets a new request in whenever it is empty or being drained.
// Reset (synchronous, active high): idle, SCL and SDA level high, SDA released, ack 1.
// Depends on i2cmps_pkg and i2cmps_phase_timer.
module i2c_master_phase_sequencer_core import i2cmps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // configuration: ticks per bus phase
   input  logic             csr_wr_en,
   input  logic [TickW-1:0] csr_wr_data,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CmdW-1:0]  req_cmd,
   input  logic [ByteW-1:0] req_data,
   input  logic             req_sda_in,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_scl,
   output logic             rsp_sda_out,
   output logic             rsp_sda_drive,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [ByteW-1:0] rsp_read_byte,
   output logic             rsp_ack_bit
);

   // Sequencer state
   logic [TickW-1:0] phase_ticks_ff;
   logic [StepW-1:0] step_ff, step_in;
   logic [ByteW-1:0] shifter_ff, shifter_in;
   logic [CmdW-1:0]  active_cmd_ff, active_cmd_in;
   bus_levels_type   levels_ff, levels_in;
   logic             ack_latch_ff, ack_latch_in;
   logic [ByteW-1:0] read_hold_ff, read_hold_in;
   logic             done_in;

   // Response register
   logic             rsp_valid_ff;
   logic             rsp_scl_ff, rsp_sda_ff, rsp_sda_en_ff;
   logic             rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [ByteW-1:0] rsp_read_ff;

   logic             accept;
   logic             expired;
   timer_ctl_type    timer_ctl;

   logic [StepW-1:0] cur_idx;
   logic [KindW-1:0] cur_kind;
   logic [KindW-1:0] next_kind;
   logic [KindW-1:0] first_kind;

   // Stall only while a response is held and the far side is not taking it.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   i2cmps_phase_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .ctl         (timer_ctl),
      .phase_ticks (phase_ticks_ff),
      .expired     (expired)
   );

   // Phase decode: current phase ends, next phase is the one at step index.
   assign cur_idx    = step_ff - StepW'(1);
   assign cur_kind   = phase_kind(active_cmd_ff, cur_idx);
   assign next_kind  = phase_kind(active_cmd_ff, step_ff);
   assign first_kind = phase_kind(req_cmd, '0);

   always_comb begin
      step_in       = step_ff;
      shifter_in    = shifter_ff;
      active_cmd_in = active_cmd_ff;
      levels_in     = levels_ff;
      ack_latch_in  = ack_latch_ff;
      read_hold_in  = read_hold_ff;
      done_in       = 1'b0;
      timer_ctl     = '0;
      if (accept) begin
         if (step_ff == '0) begin
            // Idle: take a new command, ignore none.
            if (req_cmd != CmdNone) begin
               active_cmd_in  = req_cmd;
               shifter_in     = (req_cmd == CmdRead) ? '0 : req_data;
               step_in        = StepW'(1);
               timer_ctl.load = 1'b1;
               levels_in      = enter_phase(first_kind, req_cmd, '0,
                                            shifter_in, levels_ff);
            end
         end else if (expired) begin
            // Phase over: sample on its closing tick, then advance or finish.
            if (cur_kind == KindAckHi) ack_latch_in = req_sda_in;
            if (cur_kind == KindReadHi) shifter_in = {shifter_ff[ByteW-2:0], req_sda_in};
            if (next_kind == KindEnd) begin
               if (active_cmd_ff == CmdRead) read_hold_in = shifter_in;
               step_in         = '0;
               timer_ctl.clear = 1'b1;
               done_in         = 1'b1;
            end else begin
               step_in        = step_ff + StepW'(1);
               timer_ctl.load = 1'b1;
               levels_in      = enter_phase(next_kind, active_cmd_ff, step_ff,
                                            shifter_in, levels_ff);
            end
         end else begin
            timer_ctl.count = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= TickW'(1);
         step_ff        <= '0;
         shifter_ff     <= '0;
         active_cmd_ff  <= CmdNone;
         levels_ff      <= '{scl: 1'b1, sda: 1'b1, sda_en: 1'b0};
         ack_latch_ff   <= 1'b1;
         read_hold_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) phase_ticks_ff <= csr_wr_data;
         step_ff       <= step_in;
         shifter_ff    <= shifter_in;
         active_cmd_ff <= active_cmd_in;
         levels_ff     <= levels_in;
         ack_latch_ff  <= ack_latch_in;
         read_hold_ff  <= read_hold_in;
         // Hold a response until taken; a new request replaces it in the same cycle.
         if (accept) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: load on every accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff    <= levels_in.scl;
         rsp_sda_ff    <= levels_in.sda;
         rsp_sda_en_ff <= levels_in.sda_en;
         rsp_busy_ff   <= (step_in != '0);
         rsp_done_ff   <= done_in;
         rsp_read_ff   <= read_hold_in;
         rsp_ack_ff    <= ack_latch_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = rsp_scl_ff;
   assign rsp_sda_out   = rsp_sda_ff;
   assign rsp_sda_drive = rsp_sda_en_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_read_byte = rsp_read_ff;
   assign rsp_ack_bit   = rsp_ack_ff;

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= MaxStep)
      else $error("sequencer step beyond longest phase list");

   a_busy_tracks_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_busy_ff == (step_ff != '0)))
      else $error("held busy flag disagrees with sequencer step");

   a_done_means_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (step_ff == '0) && !rsp_busy_ff)
      else $error("finished response while sequencer still active");

   a_idle_none_stays: assert property (@(posedge clock) disable iff (reset)
      (accept && step_ff == '0 && req_cmd == CmdNone) |=> (step_ff == '0))
      else $error("empty command left idle");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the I2C master phase sequencer core: random tick stream,
// an in-bench model of the bus phase sequencing, and a result checker.
// Depends on i2cmps_pkg and the i2c_master_phase_sequencer_core RTL.
`timescale 1ns / 100ps

module testbench;
   import i2cmps_pkg::*;

   localparam int unsigned CycleLimit = 100000;

   // One time-base tick offered to the block.
   typedef struct {
      logic [CmdW-1:0]  cmd;
      logic [ByteW-1:0] data;
      logic             sda;
   } bus_tick_type;

   // What the block should show after one tick.
   typedef struct packed {
      logic             scl;
      logic             sda_out;
      logic             sda_drive;
      logic             busy;
      logic             done;
      logic [ByteW-1:0] rd_byte;
      logic             ack;
   } bus_result_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [TickW-1:0] csr_wr_data = 16'd1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   logic [CmdW-1:0]  req_cmd     = CmdNone;
   logic [ByteW-1:0] req_data    = 8'h00;
   logic             req_sda_in  = 1'b1;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   logic             rsp_scl;
   logic             rsp_sda_out;
   logic             rsp_sda_drive;
   logic             rsp_busy_res;
   logic             rsp_done_res;
   logic [ByteW-1:0] rsp_read_byte;
   logic             rsp_ack_bit;

   // Handshake bookkeeping shared between the clocked processes.
   logic        req_fired     = 1'b0;
   logic        rsp_fired     = 1'b0;
   logic        long_hold_req = 1'b0;
   logic        rsp_hold_long = 1'b0;
   int unsigned send_wait     = 0;
   int unsigned stall_left    = 0;
   int unsigned send_gap_max  = 4;
   int unsigned recv_stall_max = 4;

   bus_tick_type   pending_q[$];
   bus_result_type bus_expect_q[$];

   // Run statistics and failure counters.
   int unsigned cycle_count     = 0;
   int unsigned ticks_taken     = 0;
   int unsigned results_checked = 0;
   int unsigned sequences_done  = 0;
   int unsigned cmds_issued     = 0;
   int unsigned mismatches      = 0;
   int unsigned strays          = 0;

   // Model copy of the sequencer state and of the phase length register (reset values).
   logic [TickW-1:0] phase_ticks_now = 16'd1;
   logic [StepW-1:0] seq_step        = '0;
   logic [TickW-1:0] tick_cnt        = '0;
   logic [ByteW-1:0] shift_reg       = '0;
   logic [ByteW-1:0] last_read       = '0;
   logic [CmdW-1:0]  active_cmd      = CmdNone;
   logic             scl_lvl         = 1'b1;
   logic             sda_lvl         = 1'b1;
   logic             sda_en          = 1'b0;
   logic             ack_seen        = 1'b1;

   i2c_master_phase_sequencer_core dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_data      (req_data),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl       (rsp_scl),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_byte (rsp_read_byte),
      .rsp_ack_bit   (rsp_ack_bit)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Phase n of a command; KindEnd once the list is exhausted.
   function automatic logic [KindW-1:0] phase_for(input logic [CmdW-1:0] c,
                                                  input int unsigned     n);
      int unsigned w;
      w = n;
      case (c)
         CmdStart, CmdProbe: begin
            if (n < 3) return (n == 0) ? KindDriveHi : (n == 1) ? KindSclHi : KindDriveLo;
            if (c == CmdStart) return KindEnd;
            w = n - 3;
         end
         CmdStop: return (n == 0) ? KindStopLo : (n == 1) ? KindDriveHi : KindEnd;
         CmdRead: begin
            if (n < 16) return n[0] ? KindSclLo : KindReadHi;
            return (n == 16) ? KindAckDrive : (n == 17) ? KindSclHi :
                   (n == 18) ? KindSclLo : KindEnd;
         end
         CmdSendAck: return (n == 0) ? KindAckDrive : (n == 1) ? KindSclHi :
                            (n == 2) ? KindSclLo : KindEnd;
         CmdRecvAck: return (n == 0) ? KindAckHi : (n == 1) ? KindSclLo : KindEnd;
         CmdWrite: ;
         default: return KindEnd;
      endcase
      // byte out: eight low/high bit pairs, release for the acknowledge, clock it, drop SCL
      if (w < 16) return w[0] ? KindSclHi : KindBitLow;
      return (w == 16) ? KindRelLow : (w == 17) ? KindAckHi : (w == 18) ? KindSclLo : KindEnd;
   endfunction

   // Set the bus levels that a phase names on entry; the others hold.
   task automatic take_phase_levels(input logic [KindW-1:0] kind, input int unsigned n);
      int unsigned w;
      w = (active_cmd == CmdProbe) ? n - 3 : n;
      case (kind)
         KindDriveHi: begin
            sda_en  = 1'b1;
            sda_lvl = 1'b1;
         end
         KindDriveLo: begin
            sda_en  = 1'b1;
            sda_lvl = 1'b0;
         end
         KindSclHi: scl_lvl = 1'b1;
         KindStopLo: begin
            sda_en  = 1'b1;
            sda_lvl = 1'b0;
            scl_lvl = 1'b1;
         end
         KindBitLow: begin
            scl_lvl = 1'b0;
            sda_en  = 1'b1;
            sda_lvl = shift_reg[7 - ((w >> 1) & 7)];
         end
         KindRelLow: begin
            scl_lvl = 1'b0;
            sda_en  = 1'b0;
         end
         KindAckHi, KindReadHi: begin
            sda_en  = 1'b0;
            scl_lvl = 1'b1;
         end
         KindSclLo: scl_lvl = 1'b0;
         KindAckDrive: begin
            sda_en  = 1'b1;
            sda_lvl = (active_cmd == CmdSendAck) ? shift_reg[0] : 1'b0;
         end
         default: ;
      endcase
   endtask

   // Advance the model by one accepted tick and return the levels it should show.
   task automatic step_bus_model(input logic [CmdW-1:0] c, input logic [ByteW-1:0] d,
                                 input logic sda, output bus_result_type r);
      logic [KindW-1:0] ending;
      logic [KindW-1:0] coming;
      logic [TickW-1:0] lim;
      logic             finished;
      lim      = (phase_ticks_now == 16'd0) ? 16'd1 : phase_ticks_now;
      finished = 1'b0;
      if (seq_step == 6'd0) begin
         // idle: take a command, ignore a none
         if (c != CmdNone) begin
            active_cmd = c;
            shift_reg  = (c == CmdRead) ? 8'h00 : d;
            seq_step   = 6'd1;
            tick_cnt   = 16'd1;
            take_phase_levels(phase_for(c, 0), 0);
         end
      end else if (tick_cnt >= lim) begin
         // phase over: sample where the phase asks, then enter the next or finish
         ending = phase_for(active_cmd, seq_step - 1);
         if (ending == KindAckHi) ack_seen = sda;
         if (ending == KindReadHi) shift_reg = {shift_reg[6:0], sda};
         coming = phase_for(active_cmd, seq_step);
         if (coming == KindEnd) begin
            if (active_cmd == CmdRead) last_read = shift_reg;
            seq_step = 6'd0;
            tick_cnt = 16'd0;
            finished = 1'b1;
         end else begin
            take_phase_levels(coming, seq_step);
            seq_step = seq_step + 6'd1;
            tick_cnt = 16'd1;
         end
      end else begin
         tick_cnt = tick_cnt + 16'd1;
      end
      r = '{scl: scl_lvl, sda_out: sda_lvl, sda_drive: sda_en, busy: (seq_step != 6'd0),
            done: finished, rd_byte: last_read, ack: ack_seen};
   endtask

   function automatic logic pick_sda(input int mode);
      return (mode < 0) ? 1'($urandom_range(0, 1)) : mode[0];
   endfunction

   // Queue a run of idle ticks with random data and SDA.
   task automatic idle_ticks(input int unsigned n);
      int unsigned k;
      for (k = 0; k < n; k++)
         pending_q.push_back('{CmdNone, 8'($urandom_range(0, 255)), pick_sda(-1)});
   endtask

   // Queue a command tick followed by ticks that cover its whole sequence, less cut ticks.
   // Filler ticks mostly carry no command; the rest must be ignored while busy.
   task automatic bus_command(input logic [CmdW-1:0] c, input logic [ByteW-1:0] d,
                              input int sda_mode, input int unsigned cut);
      int unsigned span;
      int unsigned lim;
      int unsigned k;
      bus_tick_type t;
      lim  = (phase_ticks_now == 16'd0) ? 1 : phase_ticks_now;
      span = 0;
      while (phase_for(c, span) != KindEnd) span++;
      span = span * lim;
      span = (cut >= span) ? 0 : span - cut;
      pending_q.push_back('{c, d, pick_sda(sda_mode)});
      for (k = 0; k < span; k++) begin
         t.cmd  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : CmdNone;
         t.data = 8'($urandom_range(0, 255));
         t.sda  = pick_sda(sda_mode);
         pending_q.push_back(t);
      end
      if (c != CmdNone) cmds_issued++;
   endtask

   // Return at a rising edge once every queued request has gone and every result has come.
   task automatic wait_for_quiet();
      do @(posedge clock);
      while (pending_q.size() != 0 || bus_expect_q.size() != 0 || req_valid);
   endtask

   // Write the phase length with the block drained, and pick the idling for the next phase.
   task automatic set_phase_ticks(input logic [TickW-1:0] v, input int unsigned gap,
                                  input int unsigned stall);
      wait_for_quiet();
      send_gap_max   = gap;
      recv_stall_max = stall;
      @(negedge clock);
      csr_wr_en       <= 1'b1;
      csr_wr_data     <= v;
      phase_ticks_now = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Request driver: hold an offered request until taken, then wait its drawn gap.
   always @(negedge clock) begin : drive_req
      bus_tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (req_valid && !req_fired) begin
         // hold: the payload stays put while stalled
      end else if (send_wait != 0) begin
         req_valid <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (pending_q.size() != 0) begin
         nxt = pending_q.pop_front();
         req_cmd    <= nxt.cmd;
         req_data   <= nxt.data;
         req_sda_in <= nxt.sda;
         req_valid  <= 1'b1;
         send_wait  <= $urandom_range(0, send_gap_max);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result stall: a drawn hold-off after each accepted result, or the long hold when asked.
   always @(negedge clock) begin : drive_rsp_stall
      int unsigned n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_hold_long) begin
         rsp_stall <= 1'b1;
      end else if (rsp_fired) begin
         n = $urandom_range(0, recv_stall_max);
         rsp_stall  <= (n != 0);
         stall_left <= (n != 0) ? n - 1 : 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Long receiver hold-off, counted here, so that the block backs up into its input.
   initial begin : rsp_long_hold
      wait (long_hold_req);
      @(posedge clock);
      rsp_hold_long = 1'b1;
      repeat (80) @(posedge clock);
      rsp_hold_long = 1'b0;
   end

   // Monitor: predict on each accepted request, check each accepted result in order.
   always @(posedge clock) begin : watch_bus
      bus_result_type want;
      bus_result_type got;
      req_fired <= !reset && req_valid && !req_stall;
      rsp_fired <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         step_bus_model(req_cmd, req_data, req_sda_in, want);
         bus_expect_q.push_back(want);
         ticks_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{scl: rsp_scl, sda_out: rsp_sda_out, sda_drive: rsp_sda_drive,
                 busy: rsp_busy_res, done: rsp_done_res, rd_byte: rsp_read_byte,
                 ack: rsp_ack_bit};
         if (bus_expect_q.size() == 0) begin
            strays++;
            if (mismatches + strays <= 10)
               $display("%0t: result with nothing outstanding: scl=%b sda=%b drv=%b busy=%b",
                        $realtime, got.scl, got.sda_out, got.sda_drive, got.busy);
         end else begin
            want = bus_expect_q.pop_front();
            results_checked++;
            if (got.done === 1'b1) sequences_done++;
            if (got !== want) begin
               mismatches++;
               if (mismatches + strays <= 10) begin
                  $display("%0t: result %0d differs (scl sda drv busy done byte ack)",
                           $realtime, results_checked);
                  $display("   expected %b %b %b %b %b %02h %b", want.scl, want.sda_out,
                           want.sda_drive, want.busy, want.done, want.rd_byte, want.ack);
                  $display("   actual   %b %b %b %b %b %02h %b", got.scl, got.sda_out,
                           got.sda_drive, got.busy, got.done, got.rd_byte, got.ack);
               end
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, bus_expect_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned lengths[3];
      int unsigned p;
      int unsigned first;
      int unsigned lim;
      int unsigned k;
      int unsigned n;
      lengths = '{1, 2, 1};
      lengths[2] = $urandom_range(1, 2);
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: every command at the reset phase length, with forced SDA where it matters.
      idle_ticks(2);                                 // idle: levels hold
      bus_command(CmdStart,   8'h00, -1, 0);
      bus_command(CmdProbe,   8'hA5,  0, 0);         // address acknowledged
      bus_command(CmdWrite,   8'hFF,  1, 0);         // all ones, not acknowledged
      bus_command(CmdWrite,   8'h00,  0, 0);         // all zeros, acknowledged
      bus_command(CmdRead,    8'h00,  1, 0);         // reads back all ones
      bus_command(CmdRead,    8'hFF,  0, 0);         // reads back all zeros
      bus_command(CmdSendAck, 8'hFE, -1, 0);         // ack level low
      bus_command(CmdSendAck, 8'h01, -1, 0);         // ack level high
      bus_command(CmdRecvAck, 8'h00,  0, 0);
      bus_command(CmdRecvAck, 8'hFF,  1, 0);
      bus_command(CmdStop,    8'h00, -1, 0);
      // a write offered mid-start must be ignored
      bus_command(CmdStart,   8'h00, -1, 2);
      bus_command(CmdWrite,   8'hC3, -1, 0);
      idle_ticks(4);

      // Zero phase length behaves as one.
      set_phase_ticks(16'd0, 4, 4);
      bus_command(CmdStart, 8'h00, -1, 0);
      bus_command(CmdWrite, 8'h81, -1, 0);
      bus_command(CmdStop,  8'h00, -1, 0);

      // Longest phase: run part of a receive-ack back to back, then shorten the phase
      // under the running count so that it closes on the next tick.
      set_phase_ticks(16'hFFFF, 0, 0);
      bus_command(CmdRecvAck, 8'h00, 1, 2 * 65535 - 20);
      set_phase_ticks(16'd1, 0, 0);
      idle_ticks(3);

      // Random transactions: mostly well-formed, some cut short or out of order.
      for (p = 0; p < 3; p++) begin
         set_phase_ticks(TickW'(lengths[p]), (p == 2) ? 0 : 4, (p == 1) ? 0 : 4);
         if (p == 1) long_hold_req = 1'b1;
         lim   = lengths[p];
         first = cmds_issued;
         while (cmds_issued - first < 4) begin
            if ($urandom_range(0, 9) < 8) begin
               if ($urandom_range(0, 1) != 0)
                  bus_command(CmdProbe, 8'($urandom_range(0, 255)), -1, 0);
               else begin
                  bus_command(CmdStart, 8'($urandom_range(0, 255)), -1, 0);
                  bus_command(CmdWrite, 8'($urandom_range(0, 255)), -1, 0);
               end
               n = $urandom_range(0, 3);
               for (k = 0; k < n; k++) begin
                  case ($urandom_range(0, 3))
                     0: bus_command(CmdWrite, 8'($urandom_range(0, 255)), -1, 0);
                     1: bus_command(CmdRead, 8'($urandom_range(0, 255)), -1, 0);
                     2: bus_command(CmdSendAck, 8'($urandom_range(0, 255)), -1, 0);
                     default: bus_command(CmdRecvAck, 8'($urandom_range(0, 255)), -1, 0);
                  endcase
               end
               bus_command(CmdStop, 8'($urandom_range(0, 255)), -1, 0);
               if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 3));
            end else begin
               // noise: any command, cut short, then idle long enough to realign
               bus_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), -1,
                           $urandom_range(1, 30));
               idle_ticks(22 * lim + 2);
            end
            // pause the sender until everything has come back
            if (p == 2) wait_for_quiet();
         end
      end

      wait_for_quiet();
      repeat (8) @(posedge clock);
      $display("covered %0d commands in %0d ticks; %0d results checked, %0d sequences done",
               cmds_issued, ticks_taken, results_checked, sequences_done);
      $display("phase lengths 0, 1, 2 and a cut 65535, long result hold-off and full drain");
      if (mismatches == 0 && strays == 0 && bus_expect_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
